>>> hdl/dso_pkg.sv
// Package for the decaying sine oscillator: item codes, constants and datapath helpers.
`default_nettype none

package dso_pkg;

  localparam int FracBits = 12;
  localparam logic [3:0] LastCrossing = 4'd15;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_NOTE = 1'b1
  } kind_e;

  // Drop v >> shift from v, worked at FracBits extra fraction bits.
  function automatic logic [31:0] decayed(logic [31:0] v, logic [4:0] shift);
    logic [31:0] w;
    w = {v[31-FracBits:0], {FracBits{1'b0}}};
    w = w - 32'($signed(w) >>> shift);
    return 32'($signed(w) >>> FracBits);
  endfunction

  // Phase step: ((3*c - p) >> 1) * fac >> FracBits, wrapping at 32 bits.
  function automatic logic [31:0] scaled_step(logic [31:0] c, logic [31:0] p,
                                              logic [11:0] fac);
    logic [31:0] t;
    logic [43:0] prod;
    t = c + {c[30:0], 1'b0} - p;
    t = 32'($signed(t) >>> 1);
    prod = {12'b0, t} * {32'b0, fac};
    return 32'($signed(prod[31:0]) >>> FracBits);
  endfunction

endpackage

`default_nettype wire

>>> hdl/decaying_sine_oscillator_top.sv
// Top level of the decaying coupled-form sine oscillator (one voice).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_ready_o | kind, freq_factor, start_magnitude,
//           |           |                      | decay_period, decay_shift
//   out     | output    | out_valid_o/out_ready_i | sample
//
// An accepted item lands in the input register and is processed from there: decay,
// phase rotation and resync run in one combinational pass into the state registers,
// so one item is taken per cycle while no tick waits; the result register takes a
// tick's sample, the sine before its update, and drives it on the output.
// A note start never waits; a tick waits in the input register only while the
// result register is full and not taken.
// Reset is asynchronous, active low, and clears valid flags and oscillator state only.
`default_nettype none

module decaying_sine_oscillator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [11:0] freq_factor_i,
  input  wire logic [18:0] start_magnitude_i,
  input  wire logic [15:0] decay_period_i,
  input  wire logic [4:0]  decay_shift_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] sample_o
);

  // input register
  logic              in_valid_q;
  dso_pkg::kind_e    kind_q;
  logic [11:0]       freq_q;
  logic [18:0]       mag_in_q;
  logic [15:0]       period_q;
  logic [4:0]        shift_in_q;

  // oscillator state
  logic [11:0] step_factor_q, step_factor_d;
  logic [15:0] decay_reload_q, decay_reload_d;
  logic [4:0]  decay_amount_q, decay_amount_d;
  logic [31:0] resync_mag_q, resync_mag_d;
  logic [31:0] cos_now_q, cos_now_d;
  logic [31:0] cos_before_q, cos_before_d;
  logic [31:0] sin_now_q, sin_now_d;
  logic [31:0] sin_before_q, sin_before_d;
  logic [3:0]  cross_cnt_q, cross_cnt_d;
  logic [15:0] countdown_q, countdown_d;

  // result register
  logic        out_valid_q;
  logic [31:0] sample_q;

  logic        is_tick;
  logic        fire;
  logic        expire;
  logic [31:0] mag_x, cb_x, cn_x, sb_x, sn_x;
  logic [31:0] nc, ns;
  logic        up;

  assign is_tick    = (kind_q == dso_pkg::KIND_TICK);
  // a tick needs room in the result register, a note start does not
  assign fire       = in_valid_q && (!is_tick || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  always_comb begin
    expire = (countdown_q == 16'd1);
    mag_x  = expire ? dso_pkg::decayed(resync_mag_q, decay_amount_q) : resync_mag_q;
    cb_x   = expire ? dso_pkg::decayed(cos_before_q, decay_amount_q) : cos_before_q;
    cn_x   = expire ? dso_pkg::decayed(cos_now_q, decay_amount_q) : cos_now_q;
    sb_x   = expire ? dso_pkg::decayed(sin_before_q, decay_amount_q) : sin_before_q;
    sn_x   = expire ? dso_pkg::decayed(sin_now_q, decay_amount_q) : sin_now_q;
    nc     = cn_x - dso_pkg::scaled_step(sn_x, sb_x, step_factor_q);
    ns     = sn_x + dso_pkg::scaled_step(cn_x, cb_x, step_factor_q);
    up     = sn_x[31] && !ns[31];
  end

  always_comb begin
    step_factor_d  = step_factor_q;
    decay_reload_d = decay_reload_q;
    decay_amount_d = decay_amount_q;
    resync_mag_d   = resync_mag_q;
    cos_now_d      = cos_now_q;
    cos_before_d   = cos_before_q;
    sin_now_d      = sin_now_q;
    sin_before_d   = sin_before_q;
    cross_cnt_d    = cross_cnt_q;
    countdown_d    = countdown_q;
    if (fire) begin
      if (!is_tick) begin
        step_factor_d  = freq_q;
        decay_reload_d = period_q;
        decay_amount_d = shift_in_q;
        resync_mag_d   = {13'b0, mag_in_q};
        cos_now_d      = {13'b0, mag_in_q};
        cos_before_d   = {13'b0, mag_in_q};
        sin_now_d      = '0;
        sin_before_d   = '0;
        cross_cnt_d    = '0;
        countdown_d    = period_q;
      end else begin
        countdown_d  = expire ? decay_reload_q : countdown_q - 16'd1;
        resync_mag_d = mag_x;
        cos_before_d = cn_x;
        sin_before_d = sn_x;
        if (up && cross_cnt_q == dso_pkg::LastCrossing) begin
          // resync to the decayed magnitude
          cos_now_d   = mag_x;
          sin_now_d   = '0;
          cross_cnt_d = '0;
        end else begin
          cos_now_d = nc;
          sin_now_d = ns;
          if (up) begin
            cross_cnt_d = cross_cnt_q + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q     <= dso_pkg::kind_e'(kind_i);
      freq_q     <= freq_factor_i;
      mag_in_q   <= start_magnitude_i;
      period_q   <= decay_period_i;
      shift_in_q <= decay_shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_factor_q  <= '0;
      decay_reload_q <= 16'd1;
      decay_amount_q <= '0;
      resync_mag_q   <= '0;
      cos_now_q      <= '0;
      cos_before_q   <= '0;
      sin_now_q      <= '0;
      sin_before_q   <= '0;
      cross_cnt_q    <= '0;
      countdown_q    <= 16'd1;
    end else begin
      step_factor_q  <= step_factor_d;
      decay_reload_q <= decay_reload_d;
      decay_amount_q <= decay_amount_d;
      resync_mag_q   <= resync_mag_d;
      cos_now_q      <= cos_now_d;
      cos_before_q   <= cos_before_d;
      sin_now_q      <= sin_now_d;
      sin_before_q   <= sin_before_d;
      cross_cnt_q    <= cross_cnt_d;
      countdown_q    <= countdown_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && is_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // the sample is the sine before this tick's update
  always_ff @(posedge clk_i) begin
    if (fire && is_tick) begin
      sample_q <= sin_now_q;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dso_checker.sv
// Port-level checker for the decaying sine oscillator, bound to the top level.
`default_nettype none

module dso_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        kind_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] sample_o
);

  logic tick_acc;
  logic note_acc;

  assign tick_acc = in_valid_i && in_ready_o && (kind_i == dso_pkg::KIND_TICK);
  assign note_acc = in_valid_i && in_ready_o && (kind_i == dso_pkg::KIND_NOTE);

  // hold a stalled sample
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled sample changed or dropped");

  // a note start never blocks the next item
  a_note_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_acc |=> in_ready_o)
    else $error("note start blocked the input");

  // an accepted tick with no sample on the output shows a sample after the result register
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc && !out_valid_o |-> ##2 out_valid_o)
    else $error("tick gave no sample");

  // a new sample needs an accepted tick behind it, through the input and result registers
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tick_acc, 2))
    else $error("sample without a tick");

endmodule

bind decaying_sine_oscillator_top dso_checker u_dso_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_o    (sample_o)
);

`default_nettype wire

>>> dv/decaying_sine_oscillator_top_tb.sv
// Testbench for decaying_sine_oscillator_top: directed and random note/tick items.
`default_nettype none

module decaying_sine_oscillator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dso_pkg::kind_e kind;
    logic [11:0]    freq;
    logic [18:0]    mag;
    logic [15:0]    period;
    logic [4:0]     shift;
  } osc_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [11:0] freq_factor_i = '0;
  logic [18:0] start_magnitude_i = '0;
  logic [15:0] decay_period_i = '0;
  logic [4:0]  decay_shift_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] sample_o;

  decaying_sine_oscillator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .freq_factor_i    (freq_factor_i),
    .start_magnitude_i(start_magnitude_i),
    .decay_period_i   (decay_period_i),
    .decay_shift_i    (decay_shift_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_o         (sample_o)
  );

  always #5 clk_i = ~clk_i;

  // Voice state as the testbench sees it
  logic [11:0] voice_freq = '0;
  logic [15:0] voice_reload = 16'd1;
  logic [4:0]  voice_shift = '0;
  logic [31:0] voice_mag = '0;
  logic [31:0] cos_cur = '0;
  logic [31:0] cos_prev = '0;
  logic [31:0] sin_cur = '0;
  logic [31:0] sin_prev = '0;
  logic [3:0]  crossings = '0;
  logic [15:0] countdown = 16'd1;

  logic [31:0] expected_samples[$];
  int unsigned errors = 0;

  bit          in_gaps_on = 1'b1;
  bit          out_gaps_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_count = 0;

  function automatic logic [31:0] decay_value(logic [31:0] v, logic [4:0] sh);
    logic signed [31:0] w;
    w = v << dso_pkg::FracBits;
    w = w - (w >>> sh);
    return w >>> dso_pkg::FracBits;
  endfunction

  function automatic logic [31:0] rotation_delta(logic [31:0] c, logic [31:0] p,
                                                 logic [11:0] f);
    logic signed [31:0] t;
    logic signed [31:0] prod;
    t = c * 32'd3 - p;
    t = t >>> 1;
    prod = t * $signed({20'd0, f});
    return prod >>> dso_pkg::FracBits;
  endfunction

  task automatic advance_voice(input osc_item_t it);
    logic [31:0] c, s, nc, ns;
    logic        rising;
    if (it.kind == dso_pkg::KIND_NOTE) begin
      voice_freq   = it.freq;
      voice_mag    = {13'd0, it.mag};
      voice_reload = it.period;
      voice_shift  = it.shift;
      cos_cur      = voice_mag;
      cos_prev     = voice_mag;
      sin_cur      = '0;
      sin_prev     = '0;
      crossings    = '0;
      countdown    = it.period;
    end else begin
      expected_samples.push_back(sin_cur);
      countdown = countdown - 16'd1;
      if (countdown == 16'd0) begin
        countdown = voice_reload;
        voice_mag = decay_value(voice_mag, voice_shift);
        cos_prev  = decay_value(cos_prev, voice_shift);
        cos_cur   = decay_value(cos_cur, voice_shift);
        sin_prev  = decay_value(sin_prev, voice_shift);
        sin_cur   = decay_value(sin_cur, voice_shift);
      end
      c = cos_cur;
      s = sin_cur;
      nc = c - rotation_delta(s, sin_prev, voice_freq);
      ns = s + rotation_delta(c, cos_prev, voice_freq);
      cos_prev = c;
      sin_prev = s;
      rising = s[31] && !ns[31];
      if (rising && crossings == dso_pkg::LastCrossing) begin
        // resync to the decayed magnitude
        cos_cur   = voice_mag;
        sin_cur   = '0;
        crossings = '0;
      end else begin
        cos_cur = nc;
        sin_cur = ns;
        if (rising) crossings = crossings + 4'd1;
      end
    end
  endtask

  function automatic osc_item_t make_tick();
    osc_item_t it;
    // unused fields still get random bits
    it.kind   = dso_pkg::KIND_TICK;
    it.freq   = 12'($urandom);
    it.mag    = 19'($urandom);
    it.period = 16'($urandom);
    it.shift  = 5'($urandom);
    return it;
  endfunction

  function automatic osc_item_t make_note(logic [11:0] f, logic [18:0] m, logic [15:0] p,
                                          logic [4:0] sh);
    osc_item_t it;
    it.kind   = dso_pkg::KIND_NOTE;
    it.freq   = f;
    it.mag    = m;
    it.period = p;
    it.shift  = sh;
    return it;
  endfunction

  task automatic send_item(input osc_item_t it);
    if (in_gaps_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= it.kind;
    freq_factor_i     <= it.freq;
    start_magnitude_i <= it.mag;
    decay_period_i    <= it.period;
    decay_shift_i     <= it.shift;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_voice(it);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(make_tick());
  endtask

  // Receiver side: random stalls, steady stretches and requested hold-offs
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_count  = 60;
    end
    if (hold_count > 0) begin
      hold_count = hold_count - 1;
      out_ready_i <= 1'b0;
    end else if (!out_gaps_on) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: sample with nothing expected, expected none, got %0d",
                 $time, $signed(sample_o));
      end else begin
        if (sample_o !== expected_samples[0]) begin
          errors++;
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, $signed(expected_samples[0]), $signed(sample_o));
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  task automatic test_ticks_after_reset();
    send_ticks(2);
  endtask

  task automatic test_field_extremes();
    // zero shift wipes the voice on the first decay
    send_item(make_note(12'hFFF, 19'h7FFFF, 16'd1, 5'd0));
    send_ticks(2);
    send_item(make_note(12'h000, 19'h00000, 16'hFFFF, 5'd31));
    send_ticks(1);
    // full scale at top frequency wraps the products
    send_item(make_note(12'hFFF, 19'h7FFFF, 16'd1, 5'd31));
    send_ticks(3);
    send_item(make_note(12'd2048, 19'd1000, 16'd2, 5'd1));
    send_ticks(4);
    send_item(make_note(12'hFFF, 19'h7FFFF, 16'd0, 5'd31));
    send_ticks(2);
  endtask

  task automatic test_resync();
    send_item(make_note(12'hFFF, 19'd200000, 16'hFFFF, 5'd31));
    send_ticks(200);
  endtask

  task automatic test_random_sequences(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    logic [15:0] per;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed note with a long run of ticks
        per = ($urandom_range(99) < 60) ? 16'($urandom_range(1, 8)) : 16'($urandom);
        send_item(make_note(12'($urandom_range(1024, 4095)), 19'($urandom), per,
                            5'($urandom_range(0, 31))));
        run = $urandom_range(20, 180);
      end else if (pick < 85) begin
        send_item(make_note(12'($urandom), 19'($urandom), 16'($urandom), 5'($urandom)));
        run = $urandom_range(0, 5);
      end else begin
        run = $urandom_range(1, 10);
      end
      send_ticks(run);
      sent += run + 1;
    end
  endtask

  task automatic test_output_hold_off();
    send_item(make_note(12'd3000, 19'd400000, 16'd3, 5'd4));
    hold_requests++;
    send_ticks(30);
  endtask

  task automatic test_zero_period_wrap();
    // a zero period wraps the countdown instead of decaying right away
    send_item(make_note(12'($urandom_range(1, 4095)), 19'h7FFFF, 16'd0, 5'd1));
    send_ticks(40);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ticks_after_reset();
    test_field_extremes();
    test_resync();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_sequences(300);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    test_output_hold_off();
    test_random_sequences(1450);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_zero_period_wrap();

    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (errors == 0 && expected_samples.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/dso_pkg.sv
hdl/decaying_sine_oscillator_top.sv
hdl/dso_checker.sv
dv/decaying_sine_oscillator_top_tb.sv
